>>> sv/gtp_pkg.sv
// shared constants, types and arctangent table for the go-to-pose velocity ramp
// no dependencies
package gtp_pkg;

   localparam int CordicStages = 16;
   localparam int AtanEntries = 24;
   localparam int NumStages = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;

   localparam logic [2:0] REG_MAX_SPEED = 3'd0;
   localparam logic [2:0] REG_FIT_SPEED = 3'd1;
   localparam logic [2:0] REG_MAX_TURN = 3'd2;
   localparam logic [2:0] REG_STEP_ACCEL = 3'd3;
   localparam logic [2:0] REG_TURN_ACCEL = 3'd4;
   localparam logic [2:0] REG_FIT_DIST = 3'd5;
   localparam logic [2:0] REG_DIST_TOL = 3'd6;
   localparam logic [2:0] REG_ANG_TOL = 3'd7;

   // vectoring word: x,y scaled by 256, x grows by the cordic gain
   localparam int VecW = 28;
   // rotation word: K in Q30 plus growth headroom
   localparam int RotW = 33;
   localparam int AngW = 20;

   localparam logic [RotW-1:0] RotStartX = RotW'(652032874);
   localparam logic [16:0] DistMul = 17'd39797;

   function automatic logic signed [AngW-1:0] atan_val(input int i);
      logic [13:0] t;
      case (i)
         0: t = 14'd8192;
         1: t = 14'd4836;
         2: t = 14'd2555;
         3: t = 14'd1297;
         4: t = 14'd651;
         5: t = 14'd326;
         6: t = 14'd163;
         7: t = 14'd81;
         8: t = 14'd41;
         9: t = 14'd20;
         10: t = 14'd10;
         11: t = 14'd5;
         12: t = 14'd3;
         13: t = 14'd1;
         14: t = 14'd1;
         default: t = 14'd0;
      endcase
      return AngW'($signed({1'b0, t}));
   endfunction

   typedef struct packed {
      logic [14:0] cruise_amp;
      logic [14:0] slow_amp;
      logic [14:0] turn_limit;
      logic [14:0] fwd_step;
      logic [14:0] turn_step;
      logic [14:0] slow_range;
      logic [14:0] distance_tolerance;
      logic [14:0] angle_tolerance;
   } cfg_type;

endpackage

>>> sv/gtp_vec_stage.sv
// one registered vectoring cordic micro-rotation
// depends on gtp_pkg
module gtp_vec_stage (
   input  logic                              clock,
   input  logic [4:0]                        shift,
   input  logic signed [gtp_pkg::AngW-1:0]   atan,
   input  logic signed [gtp_pkg::VecW-1:0]   x_in,
   input  logic signed [gtp_pkg::VecW-1:0]   y_in,
   input  logic signed [gtp_pkg::AngW-1:0]   z_in,
   output logic signed [gtp_pkg::VecW-1:0]   x_ff,
   output logic signed [gtp_pkg::VecW-1:0]   y_ff,
   output logic signed [gtp_pkg::AngW-1:0]   z_ff
);
   logic signed [gtp_pkg::VecW-1:0] dx, dy;
   assign dx = y_in >>> shift;
   assign dy = x_in >>> shift;

   always_ff @(posedge clock) begin
      if (y_in > 0) begin
         x_ff <= x_in + dx;
         y_ff <= y_in - dy;
         z_ff <= z_in + atan;
      end else begin
         x_ff <= x_in - dx;
         y_ff <= y_in + dy;
         z_ff <= z_in - atan;
      end
   end
endmodule

>>> sv/gtp_rot_stage.sv
// one registered rotation cordic micro-rotation
// depends on gtp_pkg
module gtp_rot_stage (
   input  logic                              clock,
   input  logic [4:0]                        shift,
   input  logic signed [gtp_pkg::AngW-1:0]   atan,
   input  logic signed [gtp_pkg::RotW-1:0]   x_in,
   input  logic signed [gtp_pkg::RotW-1:0]   y_in,
   input  logic signed [gtp_pkg::AngW-1:0]   z_in,
   output logic signed [gtp_pkg::RotW-1:0]   x_ff,
   output logic signed [gtp_pkg::RotW-1:0]   y_ff,
   output logic signed [gtp_pkg::AngW-1:0]   z_ff
);
   logic signed [gtp_pkg::RotW-1:0] dx, dy;
   assign dx = y_in >>> shift;
   assign dy = x_in >>> shift;

   always_ff @(posedge clock) begin
      if (z_in >= 0) begin
         x_ff <= x_in - dx;
         y_ff <= y_in + dy;
         z_ff <= z_in - atan;
      end else begin
         x_ff <= x_in + dx;
         y_ff <= y_in - dy;
         z_ff <= z_in + atan;
      end
   end
endmodule

>>> sv/go_to_pose_velocity_ramp.sv
// go-to-pose velocity ramp, one word per cycle
// the two cordic chains (vectoring, then rotation) are fully pipelined, one stage per micro-rotation
// throughput: a new word may start every cycle; busy stays low, the receiver cannot stall
// reset clears the config registers, the valid bits and so the strobe
// depends on gtp_pkg, gtp_vec_stage, gtp_rot_stage
module go_to_pose_velocity_ramp (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic signed [15:0] req_target_heading,
   input  logic signed [15:0] req_odo_heading,
   input  logic signed [15:0] req_walker_fwd,
   input  logic signed [15:0] req_walker_side,
   input  logic signed [15:0] req_walker_turn,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_data,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_fwd_amp,
   output logic signed [15:0] rsp_side_amp,
   output logic signed [15:0] rsp_turn_amp,
   output logic               rsp_arrived
);
   localparam int N = gtp_pkg::NumStages;
   localparam int VW = gtp_pkg::VecW;
   localparam int RW = gtp_pkg::RotW;
   localparam int AW = gtp_pkg::AngW;
   // pipeline positions: 0 pre, 1..N vec, N+1 dist mul, N+2 dist/diff, N+3 rot pre,
   // N+4..2N+3 rot, 2N+4 scale, 2N+5 mul, 2N+6 goal, 2N+7 out
   localparam int Depth = 2 * N + 8;

   gtp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            gtp_pkg::REG_MAX_SPEED:  cfg_ff.cruise_amp <= csr_data;
            gtp_pkg::REG_FIT_SPEED:  cfg_ff.slow_amp <= csr_data;
            gtp_pkg::REG_MAX_TURN:   cfg_ff.turn_limit <= csr_data;
            gtp_pkg::REG_STEP_ACCEL: cfg_ff.fwd_step <= csr_data;
            gtp_pkg::REG_TURN_ACCEL: cfg_ff.turn_step <= csr_data;
            gtp_pkg::REG_FIT_DIST:   cfg_ff.slow_range <= csr_data;
            gtp_pkg::REG_DIST_TOL:   cfg_ff.distance_tolerance <= csr_data;
            gtp_pkg::REG_ANG_TOL:    cfg_ff.angle_tolerance <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // side data carried along the whole pipe
   typedef struct packed {
      logic signed [15:0] th;
      logic signed [15:0] odo;
      logic signed [15:0] wf;
      logic signed [15:0] ws;
      logic signed [15:0] wt;
   } side_type;

   logic [Depth-1:0] valid_ff;
   side_type side_ff [Depth-1];
   side_type side_in;

   always_comb begin
      side_in.th = req_target_heading;
      side_in.odo = req_odo_heading;
      side_in.wf = req_walker_fwd;
      side_in.ws = req_walker_side;
      side_in.wt = req_walker_turn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Depth-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < Depth - 1; i++) side_ff[i] <= side_ff[i-1];
   end

   // ---------------- vectoring
   logic signed [VW-1:0] vx [N+1];
   logic signed [VW-1:0] vy [N+1];
   logic signed [AW-1:0] vz [N+1];
   logic signed [VW-1:0] sx, sy;

   assign sx = VW'($signed({req_target_x, 8'd0}));
   assign sy = VW'($signed({req_target_y, 8'd0}));

   always_ff @(posedge clock) begin
      if (req_target_x < 0) begin
         vx[0] <= -sx;
         vy[0] <= -sy;
         vz[0] <= AW'(32768);
      end else begin
         vx[0] <= sx;
         vy[0] <= sy;
         vz[0] <= '0;
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_vec
      gtp_vec_stage u_stage (
         .clock (clock),
         .shift (5'(g)),
         .atan  (gtp_pkg::atan_val(g)),
         .x_in  (vx[g]),
         .y_in  (vy[g]),
         .z_in  (vz[g]),
         .x_ff  (vx[g+1]),
         .y_ff  (vy[g+1]),
         .z_ff  (vz[g+1])
      );
   end

   // distance multiply
   logic signed [VW+18-1:0] dmul_ff;
   logic signed [15:0] bear_ff;
   always_ff @(posedge clock) begin
      dmul_ff <= vx[N] * $signed({1'b0, gtp_pkg::DistMul});
      bear_ff <= vz[N][15:0];
   end

   // distance and heading difference
   logic signed [VW+18-25:0] dist_w;
   assign dist_w = dmul_ff[VW+18-1:24];
   logic signed [15:0] diff_ff;
   logic far_ff, near_fit_ff;
   always_ff @(posedge clock) begin
      diff_ff <= bear_ff - side_ff[N+1].odo;
      far_ff <= dist_w > $signed({1'b0, cfg_ff.distance_tolerance});
      near_fit_ff <= dist_w < $signed({1'b0, cfg_ff.slow_range});
   end

   // rotation pre-step
   logic signed [RW-1:0] rx [N+1];
   logic signed [RW-1:0] ry [N+1];
   logic signed [AW-1:0] rz [N+1];
   logic [N+3:0] neg_ff, far_p_ff, fitsel_ff;
   logic signed [15:0] dif_p_ff [N+4];
   logic signed [AW-1:0] diff_ext;
   logic [16:0] absdiff;
   assign diff_ext = AW'(diff_ff);
   assign absdiff = diff_ff[15] ? 17'(-$signed({diff_ff[15], diff_ff})) : {1'b0, diff_ff};

   always_ff @(posedge clock) begin
      rx[0] <= gtp_pkg::RotStartX;
      ry[0] <= '0;
      if (diff_ext > AW'(16384)) begin
         rz[0] <= diff_ext - AW'(32768);
         neg_ff[0] <= 1'b1;
      end else if (diff_ext < -AW'(16384)) begin
         rz[0] <= diff_ext + AW'(32768);
         neg_ff[0] <= 1'b1;
      end else begin
         rz[0] <= diff_ext;
         neg_ff[0] <= 1'b0;
      end
      far_p_ff[0] <= far_ff;
      fitsel_ff[0] <= near_fit_ff || (absdiff > {2'b0, cfg_ff.angle_tolerance});
      dif_p_ff[0] <= diff_ff;
      for (int i = 1; i < N + 4; i++) begin
         neg_ff[i] <= neg_ff[i-1];
         far_p_ff[i] <= far_p_ff[i-1];
         fitsel_ff[i] <= fitsel_ff[i-1];
         dif_p_ff[i] <= dif_p_ff[i-1];
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_rot
      gtp_rot_stage u_stage (
         .clock (clock),
         .shift (5'(g)),
         .atan  (gtp_pkg::atan_val(g)),
         .x_in  (rx[g]),
         .y_in  (ry[g]),
         .z_in  (rz[g]),
         .x_ff  (rx[g+1]),
         .y_ff  (ry[g+1]),
         .z_ff  (rz[g+1])
      );
   end

   // scale to Q15, apply pre-rotation sign, clamp
   function automatic logic signed [17:0] q15(input logic signed [RW-1:0] v, input logic n);
      logic signed [RW-16:0] s;
      logic signed [RW-15:0] t;
      s = v[RW-1:15];
      t = n ? -$signed({s[RW-16], s}) : $signed({s[RW-16], s});
      if (t > $signed((RW-14)'(32768))) return 18'sd32768;
      if (t < -$signed((RW-14)'(32768))) return -18'sd32768;
      return 18'(t);
   endfunction

   logic signed [17:0] cos_ff, sin_ff;
   always_ff @(posedge clock) begin
      cos_ff <= q15(rx[N], neg_ff[N]);
      sin_ff <= q15(ry[N], neg_ff[N]);
   end

   // products; index N+1 of side pipes lines up with this stage
   localparam int PM = N + 1;
   logic signed [34:0] spd_ff, trn_ff;
   logic cpos_ff;
   logic [17:0] abs_s;
   assign abs_s = sin_ff[17] ? 18'(-sin_ff) : sin_ff;
   always_ff @(posedge clock) begin
      cpos_ff <= cos_ff > 0;
      spd_ff <= cos_ff * $signed({2'b0, (fitsel_ff[PM] ? cfg_ff.slow_amp
                                                      : cfg_ff.cruise_amp)});
      trn_ff <= $signed({1'b0, abs_s}) * $signed({2'b0, cfg_ff.turn_limit});
   end

   // goals
   logic signed [19:0] goal_spd_ff, goal_trn_ff;
   logic signed [19:0] gt_mag;
   assign gt_mag = 20'(trn_ff >>> 15);
   always_ff @(posedge clock) begin
      goal_spd_ff <= cpos_ff ? 20'(spd_ff >>> 15) : 20'sd0;
      goal_trn_ff <= (dif_p_ff[N+2] > 0) ? gt_mag : -gt_mag;
   end

   // output stage
   localparam int PO = Depth - 1;
   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) return 16'sh7fff;
      if (v < -19'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   side_type so;
   logic signed [18:0] wf, wt, sa, ta, mt, th, at, tc;
   assign so = side_ff[PO-1];
   assign wf = 19'(so.wf);
   assign wt = 19'(so.wt);
   assign th = 19'(so.th);
   assign sa = $signed({4'b0, cfg_ff.fwd_step});
   assign ta = $signed({4'b0, cfg_ff.turn_step});
   assign mt = $signed({4'b0, cfg_ff.turn_limit});
   assign at = $signed({4'b0, cfg_ff.angle_tolerance});

   logic signed [15:0] f_in, s_in, t_in;
   logic a_in;
   always_comb begin
      tc = '0;
      a_in = 1'b0;
      if (far_p_ff[N+3]) begin
         f_in = sat16((20'(wf) < goal_spd_ff) ? wf + sa : wf - sa);
         if (goal_spd_ff < 20'(sa)) f_in = '0;
         s_in = so.ws;
         t_in = sat16((20'(wt) < goal_trn_ff) ? wt + ta : wt - ta);
      end else begin
         f_in = '0;
         s_in = '0;
         if ((th > 0 && th > at) || (th < 0 && th < -at)) begin
            if (th < 0) begin
               tc = wt - ta;
               if (tc < -mt) tc = -mt;
            end else begin
               tc = wt + ta;
               if (tc > mt) tc = mt;
            end
            t_in = sat16(tc);
         end else begin
            t_in = '0;
            a_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_fwd_amp <= f_in;
      rsp_side_amp <= s_in;
      rsp_turn_amp <= t_in;
      rsp_arrived <= a_in;
   end

   assign rsp_strobe = valid_ff[Depth-1];

   // a result strobes only after its start has run through the whole valid chain
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(valid_ff[0], Depth - 1))
      else $error("strobe without matching start");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_arrived |-> rsp_fwd_amp == 0 && rsp_turn_amp == 0)
      else $error("arrived while still moving");
   assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
endmodule
